// ===== sv/pxc_pkg.sv =====
// Package of constants, types and register codes for the pixel hit calibrator.
package pxc_pkg;

  // Matrix side is a power of two; a pixel index is row * MATRIX_SIDE + column.
  localparam int SIDE_BITS   = 8;
  localparam int MATRIX_SIDE = 1 << SIDE_BITS;
  localparam int ROW_W       = 16 - SIDE_BITS;
  localparam int MEM_DEPTH   = 65536;

  // Pipelined long division: 64 quotient bits, DIV_BPS bits per stage.
  localparam int DIV_W      = 64;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = DIV_W / DIV_BPS;

  // Pipelined square root: 40 root bits, SQ_BPS bits per stage.
  localparam int SQ_ITERS  = 40;
  localparam int SQ_BPS    = 2;
  localparam int SQ_STAGES = SQ_ITERS / SQ_BPS;

  // Stages: input, products, sums, divider load, divider, three post stages
  // (the last of which loads the root unit), root unit.
  localparam int PIPE_STAGES = 7 + DIV_STAGES + SQ_STAGES;

  localparam logic [63:0] H_LIM = 64'd1 << 38;
  localparam logic [63:0] Q_LIM = 64'd1 << 61;

  localparam logic [15:0] PITCH_RESET  = 16'd360;
  localparam logic [15:0] MASKED_RESET = 16'd50904;

  typedef enum logic [2:0] {
    REG_ENERGY_IN_TOT = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_PIXEL_PITCH   = 3'd3,
    REG_MASKED_PIXEL  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        eid;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [52:0]        ticks;
    logic [31:0]        val;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] dd;
  } div_lane_t;

  typedef struct packed {
    side_t       side;
    div_lane_t   hl;
    div_lane_t   ql;
    logic [31:0] ua;
    logic        sh;
    logic        sq;
    logic        a_zero;
  } div_st_t;

  typedef struct packed {
    side_t              side;
    logic signed [39:0] h;
    logic [79:0]        rad;
    logic [42:0]        rem;
    logic [39:0]        root;
    logic               bad;
  } sq_st_t;

  typedef struct packed {
    logic [31:0]        eid;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [52:0]        ticks;
    logic [31:0]        energy;
    logic               energy_valid;
  } out_t;

endpackage

// ===== sv/pixel_hit_calibrator.sv =====
// Top level of the pixel hit calibrator: filter, position, time and energy pipeline.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: hit or load word, tuser: action
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: result word, tuser: energy_valid
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One word is accepted every cycle while the output buffer has room. A kept
// hit reaches the two-entry output buffer at the end of a pipeline whose
// depth is set by the 32-stage divider (two quotient bits a stage) and the
// 20-stage square root (two root bits a stage). The whole pipeline advances
// together while the buffer has room, so a full buffer holds every stage and nothing is lost or repeated.
// Reset clears the valid bits, the hit counter, the buffer and the registers.
// The calibration memory is not cleared; loads write it at accept time.
module pixel_hit_calibrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, lowest bit up: pixel[15:0], toa[63:16], ftoa[67:64],
  // tot_or_energy[99:68], coef_a[131:100], coef_b[163:132],
  // coef_c[195:164], coef_t[227:196], zero fill[231:228]
  input  logic [231:0] s_axis_tdata,
  // tuser: action (0 load calibration, 1 process hit)
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, lowest bit up: event_id[31:0], x_pos[63:32], y_pos[95:64],
  // time_ticks[148:96], energy_kev[180:149], zero fill[183:181]
  output logic [183:0] m_axis_tdata,
  // tuser: energy_valid
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NS = pxc_pkg::PIPE_STAGES;
  localparam int SB = pxc_pkg::SIDE_BITS;

  // Truncating division by 2^16 of a signed product.
  function automatic logic signed [47:0] tdiv16(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v + (v[63] ? 64'sd65535 : 64'sd0);
    return adj[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic pxc_pkg::div_lane_t div_step(input pxc_pkg::div_lane_t lane,
                                                  input logic [31:0] dv);
    pxc_pkg::div_lane_t o;
    logic [32:0] r;
    o = lane;
    for (int i = 0; i < pxc_pkg::DIV_BPS; i++) begin
      r = {o.rem, o.dd[63]};
      o.dd = {o.dd[62:0], 1'b0};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
        o.dd[0] = 1'b1;
      end
      o.rem = r[31:0];
    end
    return o;
  endfunction

  function automatic pxc_pkg::div_st_t div_adv(input pxc_pkg::div_st_t cur);
    pxc_pkg::div_st_t o;
    o = cur;
    o.hl = div_step(cur.hl, cur.ua);
    o.ql = div_step(cur.ql, cur.ua);
    return o;
  endfunction

  function automatic pxc_pkg::sq_st_t sq_step(input pxc_pkg::sq_st_t cur);
    pxc_pkg::sq_st_t o;
    logic [42:0] trial;
    o = cur;
    for (int i = 0; i < pxc_pkg::SQ_BPS; i++) begin
      o.rem = {o.rem[40:0], o.rad[79:78]};
      o.rad = {o.rad[77:0], 2'b00};
      trial = {1'b0, o.root, 2'b01};
      if (o.rem >= trial) begin
        o.rem  = o.rem - trial;
        o.root = {o.root[38:0], 1'b1};
      end else begin
        o.root = {o.root[38:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Configuration registers.
  logic               energy_in_tot;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [15:0]        pixel_pitch;
  logic [15:0]        masked_pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_in_tot <= 1'b1;
      origin_x      <= '0;
      origin_y      <= '0;
      pixel_pitch   <= pxc_pkg::PITCH_RESET;
      masked_pixel  <= pxc_pkg::MASKED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pxc_pkg::REG_ENERGY_IN_TOT: energy_in_tot <= cfg_data[0];
        pxc_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        pxc_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        pxc_pkg::REG_PIXEL_PITCH:   pixel_pitch   <= cfg_data[15:0];
        pxc_pkg::REG_MASKED_PIXEL:  masked_pixel  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [15:0] in_pixel;
  logic [47:0] in_toa;
  logic [3:0]  in_ftoa;
  logic [31:0] in_val;
  logic [127:0] in_coefs;
  logic [SB-1:0] in_col;
  logic [pxc_pkg::ROW_W-1:0] in_row;
  logic border;
  logic keep;
  logic adv;
  logic accept;

  assign in_pixel = s_axis_tdata[15:0];
  assign in_toa   = s_axis_tdata[63:16];
  assign in_ftoa  = s_axis_tdata[67:64];
  assign in_val   = s_axis_tdata[99:68];
  // Packed as {t, c, b, a} with a in the low bits.
  assign in_coefs = s_axis_tdata[227:100];
  assign in_col   = in_pixel[SB-1:0];
  assign in_row   = in_pixel[15:SB];

  // Border rows and columns, and rows past the matrix, are dropped.
  assign border = (in_col == '0) || (in_col == SB'(pxc_pkg::MATRIX_SIDE - 1)) ||
                  (in_row == '0) ||
                  (in_row >= pxc_pkg::ROW_W'(pxc_pkg::MATRIX_SIDE - 1));
  assign keep   = s_axis_tuser && !border && (in_pixel != masked_pixel);

  // Output buffer occupancy decides whether the pipeline moves this cycle.
  logic [1:0] count;
  assign adv           = (count != 2'd2);
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Calibration memory, one row of four coefficients per pixel.
  logic [127:0] cal_mem [pxc_pkg::MEM_DEPTH];
  logic [127:0] cal_q;

  always_ff @(posedge clk) begin
    if (accept && !s_axis_tuser) begin
      cal_mem[in_pixel] <= in_coefs;
    end
    if (adv) begin
      cal_q <= cal_mem[in_pixel];
    end
  end

  // Hit counter hands out event numbers at accept time.
  logic [31:0] hit_counter;
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= 32'd1;
    end else if (accept && keep) begin
      hit_counter <= hit_counter + 32'd1;
    end
  end

  // Valid bits travel alongside the data stages.
  logic [NS-1:0] v;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], accept && keep};
    end
  end

  // Stage 0: registered input fields, memory read in flight.
  logic [SB-1:0]             s0_col;
  logic [pxc_pkg::ROW_W-1:0] s0_row;
  logic [47:0]               s0_toa;
  logic [3:0]                s0_ftoa;
  logic [31:0]               s0_val;
  logic [31:0]               s0_eid;

  // Stage 1: products.
  logic signed [31:0] ca, cb, cc, ct;
  logic signed [63:0] s1_ta, s1_tb;
  logic signed [48:0] s1_ttot;
  logic signed [31:0] s1_a, s1_b, s1_c;
  logic [15:0]        s1_tot;
  logic [SB+15:0]     s1_xp;
  logic [SB+15:0]     s1_yp;
  logic [52:0]        s1_ticks;
  logic [31:0]        s1_val;
  logic [31:0]        s1_eid;

  assign ca = cal_q[31:0];
  assign cb = cal_q[63:32];
  assign cc = cal_q[95:64];
  assign ct = cal_q[127:96];

  // Stage 2: numerators of h and q, final positions.
  pxc_pkg::side_t     s2_side;
  logic signed [47:0] s2_n;
  logic signed [48:0] s2_m;
  logic signed [31:0] s2_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_col  <= in_col;
      s0_row  <= in_row;
      s0_toa  <= in_toa;
      s0_ftoa <= in_ftoa;
      s0_val  <= in_val;
      s0_eid  <= hit_counter;

      s1_ta    <= ct * ca;
      s1_tb    <= ct * cb;
      s1_ttot  <= ct * $signed({1'b0, s0_val[31:16]});
      s1_a     <= ca;
      s1_b     <= cb;
      s1_c     <= cc;
      s1_tot   <= s0_val[31:16];
      s1_xp    <= s0_col * pixel_pitch;
      s1_yp    <= s0_row * pixel_pitch;
      s1_ticks <= {1'b0, s0_toa, 4'b0000} - 53'(s0_ftoa);
      s1_val   <= s0_val;
      s1_eid   <= s0_eid;

      s2_n <= tdiv16(s1_ta) - 48'(s1_b) + $signed({16'd0, s1_tot, 16'd0});
      s2_m <= s1_ttot - 49'(tdiv16(s1_tb)) - 49'(s1_c);
      s2_a <= s1_a;
      s2_side.eid   <= s1_eid;
      s2_side.x_pos <= sat32(34'($signed({1'b0, s1_xp})) + 34'(origin_x));
      s2_side.y_pos <= sat32(34'($signed({1'b0, s1_yp})) + 34'(origin_y));
      s2_side.ticks <= s1_ticks;
      s2_side.val   <= s1_val;
    end
  end

  // Stage 3 loads the divider with magnitudes; the signs ride along.
  logic [47:0] abs_n;
  logic [48:0] abs_m;
  logic [31:0] abs_a;
  assign abs_n = s2_n[47] ? -s2_n : s2_n;
  assign abs_m = s2_m[48] ? -s2_m : s2_m;
  assign abs_a = s2_a[31] ? -s2_a : s2_a;

  pxc_pkg::div_st_t dv [pxc_pkg::DIV_STAGES + 1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].side   <= s2_side;
      dv[0].hl.rem <= '0;
      dv[0].hl.dd  <= {2'b00, abs_n[46:0], 15'd0};
      dv[0].ql.rem <= '0;
      dv[0].ql.dd  <= {abs_m[47:0], 16'd0};
      dv[0].ua     <= abs_a;
      dv[0].sh     <= s2_n[47] ^ s2_a[31];
      dv[0].sq     <= s2_m[48] ^ s2_a[31];
      dv[0].a_zero <= (s2_a == '0);
    end
  end

  for (genvar k = 1; k <= pxc_pkg::DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k] <= div_adv(dv[k-1]);
      end
    end
  end

  // Post stages: clamp quotients, square h, form the discriminant.
  logic [63:0] qh, qq;
  logic [38:0] uh_c;
  logic [61:0] qmag_c;
  assign qh     = dv[pxc_pkg::DIV_STAGES].hl.dd;
  assign qq     = dv[pxc_pkg::DIV_STAGES].ql.dd;
  assign uh_c   = (qh > pxc_pkg::H_LIM) ? pxc_pkg::H_LIM[38:0] : qh[38:0];
  assign qmag_c = (qq >= pxc_pkg::Q_LIM) ? pxc_pkg::Q_LIM[61:0] : qq[61:0];

  pxc_pkg::side_t p1_side;
  logic [38:0]    p1_uh;
  logic [61:0]    p1_qmag;
  logic           p1_sh, p1_sq, p1_az;
  logic [61:0]    p1_phi;
  logic [54:0]    p1_plo;

  pxc_pkg::side_t     p2_side;
  logic [61:0]        p2_hsq;
  logic signed [62:0] p2_qs;
  logic signed [39:0] p2_h;
  logic               p2_az;

  logic signed [63:0] d_c;
  assign d_c = $signed({2'b00, p2_hsq}) - 64'(p2_qs);

  pxc_pkg::sq_st_t sq [pxc_pkg::SQ_STAGES + 1];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side <= dv[pxc_pkg::DIV_STAGES].side;
      p1_uh   <= uh_c;
      p1_qmag <= qmag_c;
      p1_sh   <= dv[pxc_pkg::DIV_STAGES].sh;
      p1_sq   <= dv[pxc_pkg::DIV_STAGES].sq;
      p1_az   <= dv[pxc_pkg::DIV_STAGES].a_zero;
      p1_phi  <= uh_c * uh_c[38:16];
      p1_plo  <= uh_c * uh_c[15:0];

      p2_side <= p1_side;
      p2_hsq  <= p1_phi + 62'(p1_plo >> 16);
      p2_qs   <= p1_sq ? -$signed({1'b0, p1_qmag}) : $signed({1'b0, p1_qmag});
      p2_h    <= p1_sh ? -$signed({1'b0, p1_uh}) : $signed({1'b0, p1_uh});
      p2_az   <= p1_az;

      // The root unit works on d * 2^16, two bits a step from the top.
      sq[0].side <= p2_side;
      sq[0].h    <= p2_h;
      sq[0].rad  <= {d_c, 16'd0};
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].bad  <= p2_az || d_c[63];
    end
  end

  for (genvar j = 1; j <= pxc_pkg::SQ_STAGES; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j] <= sq_step(sq[j-1]);
      end
    end
  end

  // Final energy: h plus root, clamped; zero and not valid if flagged bad; or the input value in keV mode.
  logic signed [41:0] e_c;
  pxc_pkg::out_t      res;
  pxc_pkg::sq_st_t    last;
  assign last = sq[pxc_pkg::SQ_STAGES];
  assign e_c  = 42'(last.h) + $signed({2'b00, last.root});

  always_comb begin
    res.eid   = last.side.eid;
    res.x_pos = last.side.x_pos;
    res.y_pos = last.side.y_pos;
    res.ticks = last.side.ticks;
    priority if (!energy_in_tot) begin
      res.energy       = last.side.val;
      res.energy_valid = 1'b1;
    end else if (last.bad) begin
      res.energy       = '0;
      res.energy_valid = 1'b0;
    end else if (e_c[41]) begin
      res.energy       = '0;
      res.energy_valid = 1'b1;
    end else if (e_c[40:32] != '0) begin
      res.energy       = '1;
      res.energy_valid = 1'b1;
    end else begin
      res.energy       = e_c[31:0];
      res.energy_valid = 1'b1;
    end
  end

  // Two-entry output buffer; its fill level is registered so the input side
  // never waits on m_axis_tready combinationally.
  pxc_pkg::out_t obuf [2];
  logic          wr_ptr, rd_ptr;
  logic          push, pop;
  pxc_pkg::out_t head;

  assign push = adv && v[NS-1];
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign head = obuf[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = {3'b000, head.energy, head.ticks, head.y_pos, head.x_pos,
                          head.eid};
  assign m_axis_tuser  = head.energy_valid;

endmodule
